@@ rtl/tplm_pkg.sv @@
// Package for the three-phase line monitor: widths, register indexes,
// lane and result structs. Used by every module in rtl/.
package tplm_pkg;

   localparam int WINDOW_SAMPLES = 4;
   localparam int ADC_BITS       = 10;
   localparam int ADC_W          = 10;
   localparam int NUM_LINES      = 4;
   localparam int LEVEL_W        = 12;
   localparam int POS_W          = $clog2(WINDOW_SAMPLES + 1);
   localparam int THR_W          = 7;
   localparam int INTERVAL_W     = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int PHASE_W        = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_INTERVAL = 2'd2;

   localparam logic [PHASE_W-1:0] PHASE_R = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_S = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_T = 2'd2;

   localparam logic [THR_W-1:0]        THRESHOLD_RESET       = 7'd10;
   localparam logic [INTERVAL_W-1:0]   SAMPLE_INTERVAL_RESET = 16'd100;
   localparam logic [INTERVAL_W-1:0]   CHANGE_INTERVAL_RESET = 16'd1000;

   // what one lane has gathered over the current window
   typedef struct packed {
      logic               present;
      logic [LEVEL_W-1:0] sum;
   } lane_type;

   typedef struct packed {
      logic [NUM_LINES-1:0] line_status;
      logic [LEVEL_W-1:0]   level_r;
      logic [LEVEL_W-1:0]   level_s;
      logic [LEVEL_W-1:0]   level_t;
      logic [LEVEL_W-1:0]   level_g;
      logic [PHASE_W-1:0]   chosen_phase;
      logic                 status_changed;
      logic                 phase_switched;
      logic                 mains_ok;
      logic                 abnormal_mix;
      logic                 generator_start;
   } result_type;

   // per-tick events decided by the timers
   typedef struct packed {
      logic store;
      logic first;
      logic combine;
      logic reselect;
   } event_type;

endpackage

@@ rtl/tplm_lane.sv @@
// One line's window accumulator: ORs the presence bits and adds the
// readings of each stored set. Depends on tplm_pkg.
module tplm_lane
   import tplm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  event_type        evt,
   input  logic             present,
   input  logic [ADC_W-1:0] adc,
   output lane_type         lane
);

   logic               present_ff, present_in;
   logic [LEVEL_W-1:0] sum_ff, sum_in;
   logic [LEVEL_W:0]   base;
   logic [LEVEL_W:0]   wide;
   logic [LEVEL_W:0]   reading;

   always_comb begin
      reading    = (LEVEL_W + 1)'(adc[ADC_BITS-1:0]);
      base       = evt.first ? '0 : {1'b0, sum_ff};
      wide       = base + reading;
      present_in = present_ff;
      sum_in     = sum_ff;
      if (accept && evt.store) begin
         present_in = present | (present_ff & ~evt.first);
         // saturate: all terms are nonnegative, so clamping early is exact
         sum_in     = (wide > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : wide[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b1;
         sum_ff     <= '0;
      end else begin
         present_ff <= present_in;
         sum_ff     <= sum_in;
      end
   end

   assign lane.present = present_ff;
   assign lane.sum     = sum_ff;

endmodule

@@ rtl/tplm_merge.sv @@
// Merge stage: takes the four lanes' window results on a combine event,
// holds line status and levels, reselects the feeding phase and builds
// the result word. Depends on tplm_pkg.
module tplm_merge
   import tplm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  event_type            evt,
   input  logic [THR_W-1:0]     threshold,
   input  lane_type             lanes [NUM_LINES],
   output result_type           result
);

   logic [NUM_LINES-1:0] status_ff, status_in;
   logic [LEVEL_W-1:0]   level_ff [NUM_LINES];
   logic [LEVEL_W-1:0]   level_in [NUM_LINES];
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [NUM_LINES-1:0] gathered;
   logic [PHASE_W-1:0]   pick;
   logic [2:0]           mains;

   // level a times (100 - p) against level b times 100, signed
   function automatic logic beats(input logic [LEVEL_W-1:0] a,
                                  input logic [LEVEL_W-1:0] b,
                                  input logic [THR_W-1:0]   p);
      logic signed [8:0]  margin;
      logic signed [21:0] a_s, m_s, b_s, lhs, rhs;
      margin = 9'sd100 - $signed({2'b00, p});
      a_s    = $signed({10'b0, a});
      m_s    = {{13{margin[8]}}, margin};
      b_s    = $signed({10'b0, b});
      lhs    = a_s * m_s;
      rhs    = b_s * 22'sd100;
      return lhs > rhs;
   endfunction

   always_comb begin
      for (int i = 0; i < NUM_LINES; i++) begin
         gathered[i] = lanes[i].present;
         level_in[i] = (accept && evt.combine) ? lanes[i].sum : level_ff[i];
      end
      status_in = (accept && evt.combine) ? gathered : status_ff;

      if (beats(level_in[0], level_in[1], threshold))
         pick = beats(level_in[2], level_in[0], threshold) ? PHASE_T : PHASE_R;
      else
         pick = beats(level_in[2], level_in[1], threshold) ? PHASE_T : PHASE_S;
      phase_in = (accept && evt.reselect) ? pick : phase_ff;

      mains                  = status_in[2:0];
      result.line_status     = status_in;
      result.level_r         = level_in[0];
      result.level_s         = level_in[1];
      result.level_t         = level_in[2];
      result.level_g         = level_in[3];
      result.chosen_phase    = phase_in;
      result.status_changed  = evt.combine && (gathered != status_ff);
      result.phase_switched  = evt.reselect && (pick != phase_ff);
      result.mains_ok        = (mains == 3'b111);
      result.abnormal_mix    = (mains != 3'b111) && (mains != 3'b000);
      result.generator_start = (mains != 3'b111) && !status_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '1;
         phase_ff  <= PHASE_R;
         for (int i = 0; i < NUM_LINES; i++)
            level_ff[i] <= '0;
      end else begin
         status_ff <= status_in;
         phase_ff  <= phase_in;
         for (int i = 0; i < NUM_LINES; i++)
            level_ff[i] <= level_in[i];
      end
   end

endmodule

@@ rtl/three_phase_line_monitor_core.sv @@
// Top level of the three-phase line monitor: timers, window position,
// configuration registers, four lanes, merge stage and output register.
// Depends on tplm_pkg, tplm_lane and tplm_merge.
//
// Each accepted word is one time tick and yields exactly one result word
// in the next cycle. A new tick is taken every cycle while the result
// register is empty or being drained, so the block sustains one tick per
// clock; the only stall comes from rsp_ready held low. Four lanes keep a
// running OR and saturating sum of each line's stored samples, so a window
// combine and the phase reselection that follows it complete within the
// same tick. Configuration is written through csr_write_en/csr_index/
// csr_wdata (0 threshold percent, 1 sample interval, 2 change interval)
// and must only be changed while no result is pending.
module three_phase_line_monitor_core
   import tplm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_present_r,
   input  logic                   req_present_s,
   input  logic                   req_present_t,
   input  logic                   req_present_g,
   input  logic [ADC_W-1:0]       req_adc_r,
   input  logic [ADC_W-1:0]       req_adc_s,
   input  logic [ADC_W-1:0]       req_adc_t,
   input  logic [ADC_W-1:0]       req_adc_g,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [NUM_LINES-1:0]   rsp_line_status,
   output logic [LEVEL_W-1:0]     rsp_level_r,
   output logic [LEVEL_W-1:0]     rsp_level_s,
   output logic [LEVEL_W-1:0]     rsp_level_t,
   output logic [LEVEL_W-1:0]     rsp_level_g,
   output logic [PHASE_W-1:0]     rsp_chosen_phase,
   output logic                   rsp_status_changed,
   output logic                   rsp_phase_switched,
   output logic                   rsp_mains_ok,
   output logic                   rsp_abnormal_mix,
   output logic                   rsp_generator_start
);

   logic [THR_W-1:0]      threshold_ff, threshold_in;
   logic [INTERVAL_W-1:0] sample_interval_ff, sample_interval_in;
   logic [INTERVAL_W-1:0] change_interval_ff, change_interval_in;
   logic [INTERVAL_W-1:0] sample_count_ff, sample_count_in;
   logic [INTERVAL_W-1:0] change_count_ff, change_count_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic                  accept;
   logic                  sample_fire;
   logic                  change_fire;
   event_type             evt;
   lane_type              lanes [NUM_LINES];
   logic [NUM_LINES-1:0]  present;
   logic [ADC_W-1:0]      adc [NUM_LINES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign present = {req_present_g, req_present_t, req_present_s, req_present_r};
   assign adc[0]  = req_adc_r;
   assign adc[1]  = req_adc_s;
   assign adc[2]  = req_adc_t;
   assign adc[3]  = req_adc_g;

   always_comb begin
      sample_fire  = (sample_count_ff >= sample_interval_ff);
      change_fire  = (change_count_ff >= change_interval_ff);
      evt.store    = sample_fire && (pos_ff != POS_W'(WINDOW_SAMPLES));
      evt.first    = (pos_ff == '0);
      evt.combine  = sample_fire && (pos_ff == POS_W'(WINDOW_SAMPLES));
      evt.reselect = change_fire;

      sample_count_in = sample_count_ff;
      change_count_in = change_count_ff;
      pos_in          = pos_ff;
      if (accept) begin
         sample_count_in = sample_fire ? '0 : sample_count_ff + 1'b1;
         change_count_in = change_fire ? '0 : change_count_ff + 1'b1;
         if (evt.combine)
            pos_in = '0;
         else if (evt.store)
            pos_in = pos_ff + 1'b1;
      end

      threshold_in       = threshold_ff;
      sample_interval_in = sample_interval_ff;
      change_interval_in = change_interval_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD:       threshold_in       = csr_wdata[THR_W-1:0];
            CSR_SAMPLE_INTERVAL: sample_interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_CHANGE_INTERVAL: change_interval_in = csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end

      // hold the result word until it is taken
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   for (genvar g = 0; g < NUM_LINES; g++) begin : g_lane
      tplm_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .evt     (evt),
         .present (present[g]),
         .adc     (adc[g]),
         .lane    (lanes[g])
      );
   end

   tplm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .evt       (evt),
      .threshold (threshold_ff),
      .lanes     (lanes),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff       <= THRESHOLD_RESET;
         sample_interval_ff <= SAMPLE_INTERVAL_RESET;
         change_interval_ff <= CHANGE_INTERVAL_RESET;
         sample_count_ff    <= '0;
         change_count_ff    <= '0;
         pos_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         threshold_ff       <= threshold_in;
         sample_interval_ff <= sample_interval_in;
         change_interval_ff <= change_interval_in;
         sample_count_ff    <= sample_count_in;
         change_count_ff    <= change_count_in;
         pos_ff             <= pos_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_line_status     = rsp_ff.line_status;
   assign rsp_level_r         = rsp_ff.level_r;
   assign rsp_level_s         = rsp_ff.level_s;
   assign rsp_level_t         = rsp_ff.level_t;
   assign rsp_level_g         = rsp_ff.level_g;
   assign rsp_chosen_phase    = rsp_ff.chosen_phase;
   assign rsp_status_changed  = rsp_ff.status_changed;
   assign rsp_phase_switched  = rsp_ff.phase_switched;
   assign rsp_mains_ok        = rsp_ff.mains_ok;
   assign rsp_abnormal_mix    = rsp_ff.abnormal_mix;
   assign rsp_generator_start = rsp_ff.generator_start;

endmodule

@@ sim/three_phase_line_monitor_core_tb.sv @@
// Self-checking testbench for three_phase_line_monitor_core: a tick-level predictor
// feeds a queue of expected result words that is checked against every drained word.
// Depends on tplm_pkg and the RTL under rtl/.
module three_phase_line_monitor_core_tb
   import tplm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH    = WINDOW_SAMPLES * NUM_LINES;
   localparam int LONG_HOLD      = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [NUM_LINES-1:0]            present;   // 0 R, 1 S, 2 T, 3 G
      logic [NUM_LINES-1:0][ADC_W-1:0] adc;
   } tick_word_type;

   typedef enum int {LINES_UP, LINES_DOWN, LINES_MIXED, LINES_NOISE} line_mode_type;
   typedef enum int {ADC_SPREAD, ADC_CLOSE, ADC_EXTREME} adc_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_present_r = 1'b0;
   logic                   req_present_s = 1'b0;
   logic                   req_present_t = 1'b0;
   logic                   req_present_g = 1'b0;
   logic [ADC_W-1:0]       req_adc_r = '0;
   logic [ADC_W-1:0]       req_adc_s = '0;
   logic [ADC_W-1:0]       req_adc_t = '0;
   logic [ADC_W-1:0]       req_adc_g = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [NUM_LINES-1:0]   rsp_line_status;
   logic [LEVEL_W-1:0]     rsp_level_r;
   logic [LEVEL_W-1:0]     rsp_level_s;
   logic [LEVEL_W-1:0]     rsp_level_t;
   logic [LEVEL_W-1:0]     rsp_level_g;
   logic [PHASE_W-1:0]     rsp_chosen_phase;
   logic                   rsp_status_changed;
   logic                   rsp_phase_switched;
   logic                   rsp_mains_ok;
   logic                   rsp_abnormal_mix;
   logic                   rsp_generator_start;

   three_phase_line_monitor_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_present_r       (req_present_r),
      .req_present_s       (req_present_s),
      .req_present_t       (req_present_t),
      .req_present_g       (req_present_g),
      .req_adc_r           (req_adc_r),
      .req_adc_s           (req_adc_s),
      .req_adc_t           (req_adc_t),
      .req_adc_g           (req_adc_g),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_status     (rsp_line_status),
      .rsp_level_r         (rsp_level_r),
      .rsp_level_s         (rsp_level_s),
      .rsp_level_t         (rsp_level_t),
      .rsp_level_g         (rsp_level_g),
      .rsp_chosen_phase    (rsp_chosen_phase),
      .rsp_status_changed  (rsp_status_changed),
      .rsp_phase_switched  (rsp_phase_switched),
      .rsp_mains_ok        (rsp_mains_ok),
      .rsp_abnormal_mix    (rsp_abnormal_mix),
      .rsp_generator_start (rsp_generator_start)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted block state and configuration
   logic [THR_W-1:0]      est_thr          = THRESHOLD_RESET;
   logic [INTERVAL_W-1:0] est_sample_iv    = SAMPLE_INTERVAL_RESET;
   logic [INTERVAL_W-1:0] est_change_iv    = CHANGE_INTERVAL_RESET;
   logic [INTERVAL_W-1:0] est_sample_count = '0;
   logic [INTERVAL_W-1:0] est_change_count = '0;
   logic                  est_presence [STORE_DEPTH];
   logic [ADC_W-1:0]      est_reading  [STORE_DEPTH];
   int                    est_win_pos  = 0;
   logic [NUM_LINES-1:0]  est_status   = '1;
   logic [LEVEL_W-1:0]    est_level    [NUM_LINES];
   logic [PHASE_W-1:0]    est_phase    = PHASE_R;

   result_type expected_results [$];
   int         mismatches   = 0;
   bit         req_idle_en  = 1'b1;
   bit         rsp_idle_en  = 1'b1;
   bit         hold_request = 1'b0;
   int         close_base   = 0;

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         est_presence[i] = 1'b1;
         est_reading[i]  = '0;
      end
      for (int i = 0; i < NUM_LINES; i++) est_level[i] = '0;
   end

   // Store one set, or fold the full window into status and levels.
   function automatic logic take_sample(input tick_word_type t);
      logic flipped;
      logic seen;
      int   sum;
      flipped = 1'b0;
      if (est_win_pos < STORE_DEPTH) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            est_presence[est_win_pos + i] = t.present[i];
            est_reading[est_win_pos + i]  = t.adc[i];
         end
         est_win_pos += NUM_LINES;
         return 1'b0;
      end
      est_win_pos = 0;
      for (int i = 0; i < NUM_LINES; i++) begin
         seen = 1'b0;
         sum  = 0;
         for (int w = 0; w < WINDOW_SAMPLES; w++) begin
            seen |= est_presence[w * NUM_LINES + i];
            sum  += est_reading[w * NUM_LINES + i];
         end
         if (sum > int'(LEVEL_MAX)) sum = int'(LEVEL_MAX);
         if (est_status[i] != seen) flipped = 1'b1;
         est_status[i] = seen;
         est_level[i]  = sum[LEVEL_W-1:0];
      end
      return flipped;
   endfunction

   // Line i wins over level x by the threshold margin; exact signed product.
   function automatic bit outweighs(input int i, input longint x);
      longint lhs;
      longint margin;
      margin = 64'sd100 - longint'(est_thr);
      lhs    = longint'(est_level[i]) * margin;
      return lhs > x * 64'sd100;
   endfunction

   function automatic logic [PHASE_W-1:0] pick_phase();
      if (outweighs(0, longint'(est_level[1])))
         return outweighs(2, longint'(est_level[0])) ? PHASE_T : PHASE_R;
      return outweighs(2, longint'(est_level[1])) ? PHASE_T : PHASE_S;
   endfunction

   function automatic result_type predict_tick(input tick_word_type t);
      result_type         r;
      logic [PHASE_W-1:0] prior;
      logic [2:0]         mains;
      r = '0;
      if (est_sample_count >= est_sample_iv) begin
         est_sample_count = '0;
         r.status_changed = take_sample(t);
      end else begin
         est_sample_count++;
      end
      if (est_change_count >= est_change_iv) begin
         est_change_count = '0;
         prior            = est_phase;
         est_phase        = pick_phase();
         r.phase_switched = (prior != est_phase);
      end else begin
         est_change_count++;
      end
      mains             = est_status[2:0];
      r.line_status     = est_status;
      r.level_r         = est_level[0];
      r.level_s         = est_level[1];
      r.level_t         = est_level[2];
      r.level_g         = est_level[3];
      r.chosen_phase    = est_phase;
      r.mains_ok        = (mains == 3'b111);
      r.abnormal_mix    = (mains != 3'b111) && (mains != 3'b000);
      r.generator_start = (mains != 3'b111) && !est_status[3];
      return r;
   endfunction

   function automatic tick_word_type build_tick(input logic [NUM_LINES-1:0] p,
                                                input logic [ADC_W-1:0] r,
                                                input logic [ADC_W-1:0] s,
                                                input logic [ADC_W-1:0] tt,
                                                input logic [ADC_W-1:0] g);
      tick_word_type t;
      t.present = p;
      t.adc     = {g, tt, s, r};
      return t;
   endfunction

   function automatic tick_word_type make_tick(input line_mode_type mode,
                                               input adc_style_type style);
      tick_word_type t;
      case (mode)
         LINES_UP:    t.present = '1;
         LINES_DOWN:  t.present = '0;
         LINES_MIXED: t.present = {1'($urandom_range(0, 1)), 3'($urandom_range(1, 6))};
         default:     t.present = 4'($urandom_range(0, 15));
      endcase
      // a rare glitch on one line moves the OR of its window
      if ($urandom_range(0, 9) == 0) t.present[$urandom_range(0, 3)] ^= 1'b1;
      for (int i = 0; i < NUM_LINES; i++) begin
         case (style)
            ADC_SPREAD:  t.adc[i] = 10'($urandom_range(0, 1023));
            ADC_CLOSE:   t.adc[i] = 10'(close_base + $urandom_range(0, 40));
            default:     t.adc[i] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
         endcase
      end
      return t;
   endfunction

   task automatic send_tick(input tick_word_type t);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_present_r <= t.present[0];
      req_present_s <= t.present[1];
      req_present_t <= t.present[2];
      req_present_g <= t.present[3];
      req_adc_r     <= t.adc[0];
      req_adc_s     <= t.adc[1];
      req_adc_t     <= t.adc[2];
      req_adc_g     <= t.adc[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_tick(t));
      gap = (req_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write only with the line idle and every result drained.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      drain_results();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_THRESHOLD:       est_thr       = value[THR_W-1:0];
         CSR_SAMPLE_INTERVAL: est_sample_iv = value;
         CSR_CHANGE_INTERVAL: est_change_iv = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(input int thr, input int sample_iv, input int change_iv);
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_SAMPLE_INTERVAL, CSR_DATA_W'(sample_iv));
      write_reg(CSR_CHANGE_INTERVAL, CSR_DATA_W'(change_iv));
   endtask

   // Random ticks grouped into runs, sized from the sample interval, of one presence and reading style.
   task automatic run_windows(input int count);
      int            span;
      int            left;
      line_mode_type mode;
      adc_style_type style;
      int            pick;
      span = (est_sample_iv < 8) ? WINDOW_SAMPLES * (int'(est_sample_iv) + 2) : 20;
      left = 0;
      for (int n = 0; n < count; n++) begin
         if (left == 0) begin
            pick = $urandom_range(0, 9);
            mode = (pick < 5) ? LINES_UP : (pick < 7) ? LINES_DOWN :
                   (pick < 9) ? LINES_MIXED : LINES_NOISE;
            pick  = $urandom_range(0, 19);
            style = (pick < 10) ? ADC_SPREAD : (pick < 17) ? ADC_CLOSE : ADC_EXTREME;
            close_base = $urandom_range(0, 983);
            left = span;
         end
         left--;
         send_tick(make_tick(mode, style));
      end
   endtask

   task automatic test_reset_defaults();
      for (int n = 0; n < 5; n++) send_tick(make_tick(LINES_NOISE, ADC_SPREAD));
   endtask

   task automatic test_directed_windows();
      set_config(0, 0, 0);
      // full scale on every line, status unchanged
      repeat (5) send_tick(build_tick(4'hF, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
      // every line lost: status change and generator start
      repeat (5) send_tick(build_tick(4'h0, 10'd0, 10'd0, 10'd0, 10'd0));
      // R and generator only: mixed mains
      repeat (5) send_tick(build_tick(4'b1001, 10'd1023, 10'd0, 10'd512, 10'd0));
      repeat (5) send_tick(build_tick(4'b0110, 10'd0, 10'd1023, 10'd1023, 10'd0));
      // mains up, generator down
      repeat (5) send_tick(build_tick(4'b0111, 10'd100, 10'd200, 10'd300, 10'd0));
   endtask

   task automatic test_threshold_range();
      set_config(100, 0, 1);
      run_windows(12);
      // above 100 the margin turns negative
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(127));
      run_windows(12);
   endtask

   task automatic test_interval_lowering();
      set_config(10, 40, 45);
      run_windows(12);
      // drop below the running counts: both timers fire on the next tick
      write_reg(CSR_SAMPLE_INTERVAL, CSR_DATA_W'(3));
      write_reg(CSR_CHANGE_INTERVAL, CSR_DATA_W'(2));
      run_windows(16);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      run_windows(6);
   endtask

   task automatic test_random_windows();
      int thr;
      int sample_iv;
      int change_iv;
      for (int ph = 0; ph < 16; ph++) begin
         case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 100;
            2:       thr = 127;
            3:       thr = $urandom_range(0, 127);
            default: thr = $urandom_range(0, 30);
         endcase
         case ($urandom_range(0, 9))
            0:       sample_iv = 16'hFFFF;
            1:       sample_iv = $urandom_range(0, 65535);
            default: sample_iv = $urandom_range(0, 4);
         endcase
         case ($urandom_range(0, 9))
            0:       change_iv = 16'hFFFF;
            1:       change_iv = $urandom_range(0, 65535);
            default: change_iv = $urandom_range(0, 12);
         endcase
         set_config(thr, sample_iv, change_iv);
         run_windows(30);
      end
   endtask

   task automatic test_backpressure();
      set_config(5, 0, 0);
      req_idle_en = 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      run_windows(40);
      req_idle_en = 1'b1;
   endtask

   task automatic test_steady_stream();
      set_config(20, 1, 3);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      run_windows(100);
   endtask

   // Receiver: random stalls, plus one long hold when asked.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_idle_en && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result word with no expected word pending");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            compare_field("line_status", 16'(want.line_status), 16'(rsp_line_status));
            compare_field("level_r", 16'(want.level_r), 16'(rsp_level_r));
            compare_field("level_s", 16'(want.level_s), 16'(rsp_level_s));
            compare_field("level_t", 16'(want.level_t), 16'(rsp_level_t));
            compare_field("level_g", 16'(want.level_g), 16'(rsp_level_g));
            compare_field("chosen_phase", 16'(want.chosen_phase), 16'(rsp_chosen_phase));
            compare_field("status_changed", 16'(want.status_changed),
                          16'(rsp_status_changed));
            compare_field("phase_switched", 16'(want.phase_switched),
                          16'(rsp_phase_switched));
            compare_field("mains_ok", 16'(want.mains_ok), 16'(rsp_mains_ok));
            compare_field("abnormal_mix", 16'(want.abnormal_mix), 16'(rsp_abnormal_mix));
            compare_field("generator_start", 16'(want.generator_start),
                          16'(rsp_generator_start));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("three_phase_line_monitor_core test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_windows();
      test_threshold_range();
      test_interval_lowering();
      test_random_windows();
      test_backpressure();
      test_steady_stream();
      @(negedge clock);
      req_valid <= 1'b0;
      drain_results();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("three_phase_line_monitor_core test passed");
      end else begin
         $display("three_phase_line_monitor_core test failed");
      end
      $finish;
   end

endmodule
